// ===== hw/rtl/bmpu_pkg.sv =====
package bmpu_pkg;

   // field widths
   localparam int CMD_W         = 2;
   localparam int INDEX_W       = 8;
   localparam int RGB_W         = 24;
   localparam int BYTE_W        = 8;
   localparam int COORD_W       = 8;
   localparam int COLOR_W       = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 8;

   // parameter defaults
   localparam int DISPLAY_WIDTH_DEF  = 135;
   localparam int DISPLAY_HEIGHT_DEF = 240;
   localparam int PALETTE_DEPTH_DEF  = 256;

   // commands
   localparam logic [CMD_W-1:0] CMD_PAL_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DATA      = 2'd1;
   localparam logic [CMD_W-1:0] CMD_START     = 2'd2;

   // depth modes
   localparam logic [1:0] DEPTH_1  = 2'd0;
   localparam logic [1:0] DEPTH_4  = 2'd1;
   localparam logic [1:0] DEPTH_8  = 2'd2;
   localparam logic [1:0] DEPTH_24 = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_DEPTH_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DIM_LEVEL    = 2'd3;

   // register reset values
   localparam logic [1:0] RESET_DEPTH_MODE   = DEPTH_24;
   localparam logic [7:0] RESET_IMAGE_WIDTH  = 8'd135;
   localparam logic [7:0] RESET_IMAGE_HEIGHT = 8'd240;
   localparam logic [7:0] RESET_DIM_LEVEL    = 8'd255;

   // color constants
   localparam logic [7:0]  DIM_FULL = 8'hFF;
   localparam logic [15:0] MASK_RB  = 16'hF81F;
   localparam logic [15:0] MASK_G   = 16'h07E0;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic               on_screen;
      logic               last_of_run;
      logic               image_done;
   } pix_meta_type;

endpackage

// ===== hw/rtl/bmpu_req_if.sv =====
interface bmpu_req_if;
   import bmpu_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [INDEX_W-1:0] palette_index;
   logic [RGB_W-1:0]   palette_color;
   logic [BYTE_W-1:0]  data_byte;

   modport source (
      output valid, cmd, palette_index, palette_color, data_byte,
      input  ready
   );

   modport sink (
      input  valid, cmd, palette_index, palette_color, data_byte,
      output ready
   );
endinterface

// ===== hw/rtl/bmpu_rsp_if.sv =====
interface bmpu_rsp_if;
   import bmpu_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;
   logic [COLOR_W-1:0] pixel_color;
   logic               on_screen;
   logic               last_of_run;
   logic               image_done;

   modport source (
      output valid, pixel_x, pixel_y, pixel_color, on_screen, last_of_run, image_done,
      input  ready
   );

   modport sink (
      input  valid, pixel_x, pixel_y, pixel_color, on_screen, last_of_run, image_done,
      output ready
   );
endinterface

// ===== hw/rtl/bmp_pixel_unpack_rgb565.sv =====
// path: the first pixel of a byte goes from the input register through the color stage and
//   the output register to rsp; throughput: one byte per cycle in 8 and 24 bit modes while
//   rsp is not stalled; a 4 bit byte or a 1 bit byte (up to 8 pixels) is held until each of
//   its pixels is emitted, set by the one-pixel-per-cycle emitter and the single palette read port
// reset: synchronous; clears the pipeline, counters and registers to their reset values;
//   palette contents are undefined until written
module bmp_pixel_unpack_rgb565 #(
   parameter int DISPLAY_WIDTH  = bmpu_pkg::DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = bmpu_pkg::DISPLAY_HEIGHT_DEF,
   parameter int PALETTE_DEPTH  = bmpu_pkg::PALETTE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [bmpu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bmpu_pkg::CSR_DATA_W-1:0]  csr_wdata,
   bmpu_req_if.sink                         req_chan,
   bmpu_rsp_if.source                       rsp_chan
);
   import bmpu_pkg::*;

   localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   localparam logic [1:0] PHASE_BLUE  = 2'd0;
   localparam logic [1:0] PHASE_GREEN = 2'd1;

   // configuration
   logic [1:0] depth_mode_ff;
   logic [7:0] image_width_ff;
   logic [7:0] image_height_ff;
   logic [7:0] dim_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_mode_ff   <= RESET_DEPTH_MODE;
         image_width_ff  <= RESET_IMAGE_WIDTH;
         image_height_ff <= RESET_IMAGE_HEIGHT;
         dim_level_ff    <= RESET_DIM_LEVEL;
      end else if (csr_we) begin
         case (csr_index)
            REG_DEPTH_MODE:   depth_mode_ff   <= csr_wdata[1:0];
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            REG_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            REG_DIM_LEVEL:    dim_level_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   logic               h_valid_ff;
   logic [CMD_W-1:0]   h_cmd_ff;
   logic [INDEX_W-1:0] h_index_ff;
   logic [RGB_W-1:0]   h_color_ff;
   logic [BYTE_W-1:0]  h_byte_ff;
   logic [2:0]         step_ff;

   // walk state
   logic [7:0]  row_ff,     row_in;
   logic [7:0]  col_ff,     col_in;
   logic [9:0]  rbc_ff,     rbc_in;
   logic [1:0]  phase_ff,   phase_in;
   logic [15:0] partial_ff, partial_in;
   logic        finished_ff, finished_in;

   // pipeline control
   logic s2_valid_ff;
   logic out_valid_ff;
   logic adv1;
   logic adv2;
   logic step_go;
   logic step_final;
   logic emit;
   logic use_pal;
   logic pal_we;

   assign adv2    = !out_valid_ff || rsp_chan.ready;
   assign adv1    = !s2_valid_ff || adv2;
   assign step_go = h_valid_ff && adv1;
   assign req_chan.ready = !h_valid_ff || (adv1 && step_final);

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         h_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         h_cmd_ff   <= req_chan.cmd;
         h_index_ff <= req_chan.palette_index;
         h_color_ff <= req_chan.palette_color;
         h_byte_ff  <= req_chan.data_byte;
      end
   end

   // centering offsets, halved toward zero
   logic signed [9:0] x_diff, x_off, px;
   logic signed [9:0] y_diff, y_off, py;
   logic              on_x, on_y;

   assign x_diff = $signed(10'(DISPLAY_WIDTH)) - $signed({2'b00, image_width_ff});
   assign y_diff = $signed(10'(DISPLAY_HEIGHT)) - $signed({2'b00, image_height_ff});
   assign x_off  = (x_diff + $signed({9'd0, x_diff[9]})) >>> 1;
   assign y_off  = (y_diff + $signed({9'd0, y_diff[9]})) >>> 1;
   assign px     = $signed({2'b00, col_ff}) + x_off;
   assign py     = $signed({2'b00, row_ff}) + y_off;
   assign on_x   = !px[9] && (px < $signed(10'(DISPLAY_WIDTH)));
   assign on_y   = !py[9] && (py < $signed(10'(DISPLAY_HEIGHT)));

   // padded row length in bytes
   logic [12:0] row_bits;
   logic [12:0] row_bits_up;
   logic [9:0]  line_len;

   always_comb begin
      case (depth_mode_ff)
         DEPTH_1:  row_bits = {5'd0, image_width_ff};
         DEPTH_4:  row_bits = {3'd0, image_width_ff, 2'b00};
         DEPTH_8:  row_bits = {2'd0, image_width_ff, 3'b000};
         default:  row_bits = {1'b0, image_width_ff, 4'b0000} + {2'd0, image_width_ff, 3'b000};
      endcase
   end

   assign row_bits_up = row_bits + 13'd31;
   assign line_len    = {row_bits_up[12:5], 2'b00};

   // palette index of the current step, msb first
   logic [INDEX_W-1:0] lookup_idx;
   logic [2:0]         step_last;
   logic               lookup_in_range;
   logic               write_in_range;

   always_comb begin
      case (depth_mode_ff)
         DEPTH_1: begin
            lookup_idx = {7'd0, h_byte_ff[3'd7 - step_ff]};
            step_last  = 3'd7;
         end
         DEPTH_4: begin
            lookup_idx = step_ff[0] ? {4'd0, h_byte_ff[3:0]} : {4'd0, h_byte_ff[7:4]};
            step_last  = 3'd1;
         end
         default: begin
            lookup_idx = h_byte_ff;
            step_last  = 3'd0;
         end
      endcase
   end

   assign lookup_in_range = {1'b0, lookup_idx} < 9'(PALETTE_DEPTH);
   assign write_in_range  = {1'b0, h_index_ff} < 9'(PALETTE_DEPTH);

   logic [7:0]       col_plus;
   logic             col_lt_w;
   logic [7:0]       col_tmp;
   logic [9:0]       rbc_tmp;
   logic [RGB_W-1:0] direct_rgb;

   assign col_plus = col_ff + 8'd1;
   assign col_lt_w = col_ff < image_width_ff;

   always_comb begin
      emit        = 1'b0;
      step_final  = 1'b1;
      use_pal     = 1'b0;
      pal_we      = 1'b0;
      direct_rgb  = '0;
      col_tmp     = col_ff;
      rbc_tmp     = rbc_ff + 10'd1;
      row_in      = row_ff;
      col_in      = col_ff;
      rbc_in      = rbc_ff;
      phase_in    = phase_ff;
      partial_in  = partial_ff;
      finished_in = finished_ff;
      case (h_cmd_ff)
         CMD_PAL_WRITE: begin
            pal_we = write_in_range;
         end
         CMD_START: begin
            row_in      = image_height_ff - 8'd1;
            col_in      = '0;
            rbc_in      = '0;
            phase_in    = PHASE_BLUE;
            partial_in  = '0;
            finished_in = 1'b0;
         end
         CMD_DATA: begin
            if (!finished_ff) begin
               if (depth_mode_ff == DEPTH_24) begin
                  if (col_lt_w) begin
                     if (phase_ff == PHASE_BLUE) begin
                        partial_in = {8'h00, h_byte_ff};
                        phase_in   = PHASE_GREEN;
                     end else if (phase_ff == PHASE_GREEN) begin
                        partial_in = partial_ff | {h_byte_ff, 8'h00};
                        phase_in   = 2'd2;
                     end else begin
                        // red byte completes the pixel
                        emit       = 1'b1;
                        direct_rgb = {h_byte_ff, partial_ff};
                        phase_in   = PHASE_BLUE;
                        partial_in = '0;
                        col_tmp    = col_plus;
                     end
                  end
               end else begin
                  use_pal = 1'b1;
                  if (col_lt_w) begin
                     emit       = 1'b1;
                     col_tmp    = col_plus;
                     step_final = (step_ff == step_last) || (col_plus == image_width_ff);
                  end
               end
               col_in = col_tmp;
               if (step_final) begin
                  rbc_in = rbc_tmp;
                  if (rbc_tmp >= line_len) begin
                     rbc_in     = '0;
                     col_in     = '0;
                     phase_in   = PHASE_BLUE;
                     partial_in = '0;
                     if (row_ff == 8'd0) begin
                        finished_in = 1'b1;
                     end else begin
                        row_in = row_ff - 8'd1;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= RESET_IMAGE_HEIGHT - 8'd1;
         col_ff      <= '0;
         rbc_ff      <= '0;
         phase_ff    <= PHASE_BLUE;
         partial_ff  <= '0;
         finished_ff <= 1'b0;
         step_ff     <= '0;
      end else if (step_go) begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         rbc_ff      <= rbc_in;
         phase_ff    <= phase_in;
         partial_ff  <= partial_in;
         finished_ff <= finished_in;
         step_ff     <= step_final ? 3'd0 : step_ff + 3'd1;
      end
   end

   // palette
   logic [RGB_W-1:0] pal_rd_data;

   bmpu_palette_ram #(
      .DEPTH (PALETTE_DEPTH)
   ) u_palette_ram (
      .clock   (clock),
      .wr_en   (step_go && pal_we),
      .wr_addr (h_index_ff[PAL_AW-1:0]),
      .wr_data (h_color_ff),
      .rd_en   (step_go && emit && use_pal),
      .rd_addr (lookup_idx[PAL_AW-1:0]),
      .rd_data (pal_rd_data)
   );

   // color stage
   pix_meta_type     s2_meta_ff;
   logic             s2_use_pal_ff;
   logic             s2_pal_zero_ff;
   logic [RGB_W-1:0] s2_rgb_ff;
   pix_meta_type     meta_in;

   assign meta_in.pixel_x     = px[7:0];
   assign meta_in.pixel_y     = py[7:0];
   assign meta_in.on_screen   = on_x && on_y;
   assign meta_in.last_of_run = step_final;
   assign meta_in.image_done  = (row_ff == 8'd0) && (col_plus == image_width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv1) begin
         s2_valid_ff <= step_go && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && emit) begin
         s2_meta_ff     <= meta_in;
         s2_use_pal_ff  <= use_pal;
         s2_pal_zero_ff <= !lookup_in_range;
         s2_rgb_ff      <= direct_rgb;
      end
   end

   logic [RGB_W-1:0]   shade_rgb;
   logic [COLOR_W-1:0] shade_color;

   // out-of-range palette index reads as black
   assign shade_rgb = s2_use_pal_ff ? (s2_pal_zero_ff ? '0 : pal_rd_data) : s2_rgb_ff;

   bmpu_shade u_shade (
      .rgb       (shade_rgb),
      .dim_level (dim_level_ff),
      .color     (shade_color)
   );

   // output register
   pix_meta_type       out_meta_ff;
   logic [COLOR_W-1:0] out_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv2) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2 && s2_valid_ff) begin
         out_meta_ff  <= s2_meta_ff;
         out_color_ff <= shade_color;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.pixel_x     = out_meta_ff.pixel_x;
   assign rsp_chan.pixel_y     = out_meta_ff.pixel_y;
   assign rsp_chan.pixel_color = out_color_ff;
   assign rsp_chan.on_screen   = out_meta_ff.on_screen;
   assign rsp_chan.last_of_run = out_meta_ff.last_of_run;
   assign rsp_chan.image_done  = out_meta_ff.image_done;
endmodule

// ===== hw/rtl/bmpu_palette_ram.sv =====
module bmpu_palette_ram #(
   parameter  int DEPTH = bmpu_pkg::PALETTE_DEPTH_DEF,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [bmpu_pkg::RGB_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [bmpu_pkg::RGB_W-1:0] rd_data
);
   import bmpu_pkg::*;

   logic [RGB_W-1:0] mem [DEPTH];
   logic [RGB_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/bmpu_shade.sv =====
module bmpu_shade (
   input  logic [bmpu_pkg::RGB_W-1:0]   rgb,
   input  logic [7:0]                   dim_level,
   output logic [bmpu_pkg::COLOR_W-1:0] color
);
   import bmpu_pkg::*;

   logic [COLOR_W-1:0] base;
   logic [21:0]        prod_rb;
   logic [23:0]        prod_g;
   logic [COLOR_W-1:0] dim_rb;
   logic [COLOR_W-1:0] dim_g;

   // 8:8:8 down to 5:6:5
   assign base    = {rgb[23:19], rgb[15:10], rgb[7:3]};

   // red and blue scale by alpha/4 over 64, green by alpha over 256
   assign prod_rb = 22'(base & MASK_RB) * 22'(dim_level[7:2]);
   assign prod_g  = 24'(base & MASK_G) * 24'(dim_level);
   assign dim_rb  = prod_rb[21:6] & MASK_RB;
   assign dim_g   = prod_g[23:8] & MASK_G;

   assign color   = (dim_level < DIM_FULL) ? (dim_rb | dim_g) : base;
endmodule

// ===== hw/rtl/bmpu_checker.sv =====
module bmpu_checker #(
   parameter int DISPLAY_WIDTH  = bmpu_pkg::DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = bmpu_pkg::DISPLAY_HEIGHT_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [bmpu_pkg::COORD_W-1:0] pixel_x,
   input logic [bmpu_pkg::COORD_W-1:0] pixel_y,
   input logic [bmpu_pkg::COLOR_W-1:0] pixel_color,
   input logic                         on_screen,
   input logic                         last_of_run,
   input logic                         image_done
);
   import bmpu_pkg::*;

   // nothing comes out right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped without transfer");

   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(pixel_x) && $stable(pixel_y)
         && $stable(pixel_color) && $stable(on_screen) && $stable(last_of_run)
         && $stable(image_done))
      else $error("rsp payload changed while stalled");

   // the final pixel of an image always closes its byte
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && image_done |-> last_of_run)
      else $error("image done without last of run");

   a_on_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && on_screen |->
         (pixel_x < COORD_W'(DISPLAY_WIDTH)) && (pixel_y < COORD_W'(DISPLAY_HEIGHT)))
      else $error("on screen pixel outside display");
endmodule

bind bmp_pixel_unpack_rgb565 bmpu_checker #(
   .DISPLAY_WIDTH  (DISPLAY_WIDTH),
   .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
) u_bmpu_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .pixel_x     (rsp_chan.pixel_x),
   .pixel_y     (rsp_chan.pixel_y),
   .pixel_color (rsp_chan.pixel_color),
   .on_screen   (rsp_chan.on_screen),
   .last_of_run (rsp_chan.last_of_run),
   .image_done  (rsp_chan.image_done)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import bmpu_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_ITEMS  = 150;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [COLOR_W-1:0] pixel_color;
      logic               on_screen;
      logic               last_of_run;
      logic               image_done;
   } pixel_rec;

   class unpack_scoreboard;
      logic [1:0]       depth;
      logic [7:0]       width, height, dim;
      logic [RGB_W-1:0] palette [PALETTE_DEPTH_DEF];
      bit               written [PALETTE_DEPTH_DEF];
      logic [7:0]       written_list [$];
      logic [7:0]       row, col;
      logic [9:0]       row_bytes;
      logic [1:0]       phase;
      logic [15:0]      partial;
      bit               finished;
      pixel_rec         batch [$];
      pixel_rec         expected_pixels [$];
      int               errors;

      function new();
         depth  = RESET_DEPTH_MODE;
         width  = RESET_IMAGE_WIDTH;
         height = RESET_IMAGE_HEIGHT;
         dim    = RESET_DIM_LEVEL;
         errors = 0;
         restart();
      endfunction

      function void restart();
         row       = height - 8'd1;
         col       = 8'd0;
         row_bytes = 10'd0;
         phase     = 2'd0;
         partial   = 16'd0;
         finished  = 1'b0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_DEPTH_MODE:   depth  = value[1:0];
            REG_IMAGE_WIDTH:  width  = value;
            REG_IMAGE_HEIGHT: height = value;
            REG_DIM_LEVEL:    dim    = value;
            default: ;
         endcase
      endfunction

      function logic [COLOR_W-1:0] blend_565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
         logic [15:0] c;
         int unsigned lanes, rb, gg;
         c = {r[7:3], g[7:2], b[7:3]};
         if (dim != DIM_FULL) begin
            lanes = c & MASK_RB;
            rb    = ((lanes * (dim >> 2)) >> 6) & MASK_RB;
            lanes = c & MASK_G;
            gg    = ((lanes * dim) >> 8) & MASK_G;
            c     = 16'(rb | gg);
         end
         return c;
      endfunction

      function void place(logic [15:0] color);
         int xoff, yoff, px, py;
         pixel_rec p;
         xoff = (DISPLAY_WIDTH_DEF - int'(width)) / 2;
         yoff = (DISPLAY_HEIGHT_DEF - int'(height)) / 2;
         px   = int'(col) + xoff;
         py   = int'(row) + yoff;
         col  = col + 8'd1;
         p.pixel_x     = px[7:0];
         p.pixel_y     = py[7:0];
         p.pixel_color = color;
         p.on_screen   = px >= 0 && px < DISPLAY_WIDTH_DEF && py >= 0 && py < DISPLAY_HEIGHT_DEF;
         p.last_of_run = 1'b0;
         // done flag looks at the column after it has advanced
         p.image_done  = (row == 8'd0) && (col == width);
         batch.push_back(p);
      endfunction

      function void take_item(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] index,
                              logic [RGB_W-1:0] rgb, logic [BYTE_W-1:0] data);
         int bpp, line, per;
         logic [7:0] sel;
         logic [RGB_W-1:0] entry;
         case (cmd)
            CMD_PAL_WRITE: begin
               palette[index] = rgb;
               if (!written[index]) begin
                  written[index] = 1'b1;
                  written_list.push_back(index);
               end
            end
            CMD_START: restart();
            CMD_DATA: begin
               if (finished)
                  return;
               batch.delete();
               case (depth)
                  DEPTH_1: bpp = 1;
                  DEPTH_4: bpp = 4;
                  DEPTH_8: bpp = 8;
                  default: bpp = 24;
               endcase
               line = ((bpp * int'(width) + 31) >> 5) * 4;
               if (bpp == 24) begin
                  if (col < width) begin
                     case (phase)
                        2'd0: begin
                           partial = {8'h00, data};
                           phase   = 2'd1;
                        end
                        2'd1: begin
                           partial[15:8] = data;
                           phase         = 2'd2;
                        end
                        default: begin
                           place(blend_565(data, partial[15:8], partial[7:0]));
                           phase   = 2'd0;
                           partial = 16'd0;
                        end
                     endcase
                  end
               end else begin
                  per = 8 / bpp;
                  // leftmost pixel sits in the high bits of the byte
                  for (int k = 0; k < per && col < width; k++) begin
                     sel   = (data >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1);
                     entry = palette[sel];
                     place(blend_565(entry[23:16], entry[15:8], entry[7:0]));
                  end
               end
               if (batch.size() > 0)
                  batch[batch.size() - 1].last_of_run = 1'b1;
               foreach (batch[i])
                  expected_pixels.push_back(batch[i]);
               row_bytes = row_bytes + 10'd1;
               if (int'(row_bytes) >= line) begin
                  row_bytes = 10'd0;
                  col       = 8'd0;
                  phase     = 2'd0;
                  partial   = 16'd0;
                  if (row == 8'd0)
                     finished = 1'b1;
                  else
                     row = row - 8'd1;
               end
            end
            default: ;
         endcase
      endfunction

      // a byte whose every palette lookup hits an entry already written
      function logic [7:0] legal_byte();
         if (depth == DEPTH_8)
            return written_list[$urandom_range(0, written_list.size() - 1)];
         return 8'($urandom_range(0, 255));
      endfunction

      function void compare(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
         end
      endfunction

      function void match_pixel(pixel_rec got);
         pixel_rec want;
         if (expected_pixels.size() == 0) begin
            $error("pixel at x %0d y %0d with nothing expected", got.pixel_x, got.pixel_y);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         compare("pixel_x", want.pixel_x, got.pixel_x);
         compare("pixel_y", want.pixel_y, got.pixel_y);
         compare("pixel_color", want.pixel_color, got.pixel_color);
         compare("on_screen", want.on_screen, got.on_screen);
         compare("last_of_run", want.last_of_run, got.last_of_run);
         compare("image_done", want.image_done, got.image_done);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     send_idle_pct;
   int                     sink_stall_pct;
   int                     counted;
   unpack_scoreboard       sb = new();

   bmpu_req_if req_chan ();
   bmpu_rsp_if rsp_chan ();

   bmp_pixel_unpack_rgb565 dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      pixel_rec seen;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.take_item(req_chan.cmd, req_chan.palette_index, req_chan.palette_color,
                         req_chan.data_byte);
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.pixel_x     = rsp_chan.pixel_x;
            seen.pixel_y     = rsp_chan.pixel_y;
            seen.pixel_color = rsp_chan.pixel_color;
            seen.on_screen   = rsp_chan.on_screen;
            seen.last_of_run = rsp_chan.last_of_run;
            seen.image_done  = rsp_chan.image_done;
            sb.match_pixel(seen);
         end
      end
   end

   // called and returning just after a falling edge; valid stays up after the transfer
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] index,
                            input logic [RGB_W-1:0] rgb, input logic [BYTE_W-1:0] data);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.cmd           <= cmd;
      req_chan.palette_index <= index;
      req_chan.palette_color <= rgb;
      req_chan.data_byte     <= data;
      req_chan.valid         <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (sb.expected_pixels.size() != 0)
         @(negedge clock);
      // a byte that emits no pixel can still be in the unpacker when nothing more is expected
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic [1:0] d, input logic [7:0] w, input logic [7:0] h,
                            input logic [7:0] dm);
      logic [CSR_INDEX_W-1:0] regs [4] = '{REG_DEPTH_MODE, REG_IMAGE_WIDTH,
                                           REG_IMAGE_HEIGHT, REG_DIM_LEVEL};
      logic [CSR_DATA_W-1:0]  vals [4];
      vals = '{{6'd0, d}, w, h, dm};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         sb.set_reg(regs[i], vals[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic ensure_palette();
      int needed;
      needed = (sb.depth == DEPTH_1) ? 2 : (sb.depth == DEPTH_4) ? 16 : 0;
      for (int i = 0; i < needed; i++) begin
         if (!sb.written[i]) begin
            send_item(CMD_PAL_WRITE, 8'(i), 24'($urandom), 8'($urandom));
            counted++;
         end
      end
   endtask

   task automatic run_image();
      logic [1:0] d;
      logic [7:0] w, h, dm;
      int bpp, line, total, cap, sent, split;
      if (counted < RANDOM_ITEMS / 3) begin
         send_idle_pct  = 35;
         sink_stall_pct = 77;
      end else if (counted < 2 * RANDOM_ITEMS / 3) begin
         send_idle_pct  = 77;
         sink_stall_pct = 35;
      end else begin
         send_idle_pct  = 0;
         sink_stall_pct = 0;
      end
      d = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 19))
         0:       w = 8'd255;
         1:       w = 8'd0;
         default: w = 8'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 19))
         0:       h = 8'd255;
         1:       h = 8'd0;
         default: h = 8'($urandom_range(1, 3));
      endcase
      case ($urandom_range(0, 5))
         0:       dm = 8'd0;
         1:       dm = 8'd254;
         2, 3:    dm = DIM_FULL;
         default: dm = 8'($urandom_range(0, 255));
      endcase
      drain();
      configure(d, w, h, dm);
      ensure_palette();
      send_item(CMD_START, 8'($urandom), 24'($urandom), 8'($urandom));
      counted++;
      bpp   = (d == DEPTH_1) ? 1 : (d == DEPTH_4) ? 4 : (d == DEPTH_8) ? 8 : 24;
      line  = ((bpp * int'(w) + 31) >> 5) * 4;
      total = ((h == 8'd0) ? 256 : int'(h)) * ((line == 0) ? 1 : line);
      // big frames and a few small ones get cut short
      cap = total;
      if (total > 60 || $urandom_range(0, 7) == 0)
         cap = $urandom_range(1, (total < 30) ? total : 30);
      split = ($urandom_range(0, 5) == 0) ? cap / 2 : -1;
      sent  = 0;
      while (sent < cap && !sb.finished) begin
         if (sent == split && split > 0) begin
            drain();
            case ($urandom_range(0, 3))
               0: configure(2'($urandom_range(0, 3)), sb.width, sb.height, sb.dim);
               1: configure(sb.depth, 8'($urandom_range(0, 12)), sb.height, sb.dim);
               2: configure(sb.depth, sb.width, 8'($urandom_range(0, 255)), sb.dim);
               default: configure(sb.depth, sb.width, sb.height, 8'($urandom_range(0, 255)));
            endcase
            ensure_palette();
         end
         if ($urandom_range(0, 14) == 0) begin
            send_item(CMD_PAL_WRITE, 8'($urandom), 24'($urandom), 8'($urandom));
            counted++;
         end
         if ($urandom_range(0, 29) == 0)
            send_item(CMD_UNUSED, 8'($urandom), 24'($urandom), 8'($urandom));
         send_item(CMD_DATA, 8'($urandom), 24'($urandom), sb.legal_byte());
         sent++;
         counted++;
      end
      if (sb.finished && $urandom_range(0, 3) == 0)
         send_item(CMD_DATA, 8'($urandom), 24'($urandom), sb.legal_byte());
   endtask

   initial begin
      logic [7:0] rgb_bytes [9] = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                                    8'h5A, 8'hA5, 8'h77};
      logic [7:0] mono_bytes [4] = '{8'hA5, 8'h80, 8'h00, 8'h00};
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = '0;
      csr_wdata              = '0;
      req_chan.valid         = 1'b0;
      req_chan.cmd           = CMD_PAL_WRITE;
      req_chan.palette_index = '0;
      req_chan.palette_color = '0;
      req_chan.data_byte     = '0;
      rsp_chan.ready         = 1'b0;
      send_idle_pct          = 35;
      sink_stall_pct         = 77;
      counted                = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // two 24 bit pixels, two pad bytes, then a byte past the end of the image
      configure(DEPTH_24, 8'd2, 8'd1, DIM_FULL);
      send_item(CMD_PAL_WRITE, 8'd0, 24'h000000, 8'h00);
      send_item(CMD_PAL_WRITE, 8'd1, 24'hFFFFFF, 8'hFF);
      send_item(CMD_PAL_WRITE, 8'd255, 24'h3C5AA5, 8'h00);
      send_item(CMD_UNUSED, 8'hFF, 24'hFFFFFF, 8'hFF);
      send_item(CMD_START, 8'h00, 24'h000000, 8'h00);
      foreach (rgb_bytes[i])
         send_item(CMD_DATA, 8'h00, 24'h000000, rgb_bytes[i]);
      drain();

      // 1 bit row of nine pixels: full byte, one pixel, padding
      configure(DEPTH_1, 8'd9, 8'd1, 8'd254);
      send_item(CMD_START, 8'h00, 24'h000000, 8'h00);
      foreach (mono_bytes[i])
         send_item(CMD_DATA, 8'h00, 24'h000000, mono_bytes[i]);
      drain();

      // zero width: each byte closes a row and nothing comes out
      configure(DEPTH_8, 8'd0, 8'd2, 8'd0);
      send_item(CMD_START, 8'h00, 24'h000000, 8'h00);
      send_item(CMD_DATA, 8'h00, 24'h000000, 8'hFF);
      send_item(CMD_DATA, 8'h00, 24'h000000, 8'h00);

      while (counted < RANDOM_ITEMS)
         run_image();
      drain();

      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/bmpu_pkg.sv
hw/rtl/bmpu_req_if.sv
hw/rtl/bmpu_rsp_if.sv
hw/rtl/bmpu_palette_ram.sv
hw/rtl/bmpu_shade.sv
hw/rtl/bmp_pixel_unpack_rgb565.sv
hw/rtl/bmpu_checker.sv
tb/testbench.sv
